// ----- hdl/ofip_pkg.sv -----
// Shared constants, character codes and result types of the face index parser.
package ofip_pkg;

	localparam int INDEX_BITS = 24;
	localparam int VC_W = 24;
	localparam int IDX_W = 25;
	localparam int CALC_W = ((INDEX_BITS > VC_W) ? INDEX_BITS : VC_W) + 2;
	localparam int PROD_W = INDEX_BITS + 4;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	localparam logic [1:0] LAST_FIELD = 2'd2;

	typedef struct packed {
		logic signed [IDX_W-1:0] v_index;
		logic signed [IDX_W-1:0] t_index;
		logic signed [IDX_W-1:0] n_index;
		logic                    last;
		logic                    overflow;
	} vert_t;

	typedef struct packed {
		logic [1:0] num;
		vert_t      first;
		vert_t      second;
	} push_t;

endpackage

// ----- hdl/ofip_char_if.sv -----
// Request channel that carries one character of a face line.
interface ofip_char_if import ofip_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [7:0]      ch;
	logic            end_of_line;
	logic [VC_W-1:0] vertex_count;

	modport source (output valid, ch, end_of_line, vertex_count, input ready);
	modport sink (input valid, ch, end_of_line, vertex_count, output ready);
endinterface

// ----- hdl/ofip_vert_if.sv -----
// Request channel that carries one parsed face vertex.
interface ofip_vert_if import ofip_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [IDX_W-1:0] v_index;
	logic signed [IDX_W-1:0] t_index;
	logic signed [IDX_W-1:0] n_index;
	logic                    last;
	logic                    overflow;

	modport source (output valid, v_index, t_index, n_index, last, overflow, input ready);
	modport sink (input valid, v_index, t_index, n_index, last, overflow, output ready);
endinterface

// ----- hdl/obj_face_index_parser_unit.sv -----
// Top level of the face line index parser.
// A completed vertex passes through the input register and the result queue before it is offered.
// Throughput: one character request per cycle while the result consumer keeps up.
// The four-entry result queue stalls the input when fewer than two slots are free.
// Reset clears all token state, the held vertex flag and the result queue at once.
module obj_face_index_parser_unit import ofip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ofip_char_if.sink   chars,
	ofip_vert_if.source verts
);

	push_t push;
	logic  room;

	ofip_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.room   (room),
		.push   (push)
	);

	ofip_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.verts  (verts)
	);

endmodule

// ----- hdl/ofip_core.sv -----
// Input register and combinational character parser with token state.
module ofip_core import ofip_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ofip_char_if.sink     chars,
	input  logic          room,
	output push_t         push
);

	typedef struct packed {
		logic signed [IDX_W-1:0] r;
		logic                    ovf;
	} fin_t;

	localparam logic signed [CALC_W-1:0] ONE_C    = CALC_W'(1);
	localparam logic signed [CALC_W-1:0] MINUS1_C = '1;
	localparam logic signed [CALC_W-1:0] OUTMAX_C = CALC_W'((64'd1 << VC_W) - 64'd1);
	localparam logic [PROD_W-1:0]        ACCMAX_C = PROD_W'((64'd1 << INDEX_BITS) - 64'd1);
	localparam logic signed [IDX_W-1:0]  NONE_C   = '1;

	logic                    valid_s1;
	logic [7:0]              ch_s1;
	logic                    eol_s1;
	logic [VC_W-1:0]         vc_s1;

	logic [INDEX_BITS-1:0]   acc_q, acc_d;
	logic [1:0]              fpos_q, fpos_d;
	logic                    neg_q, neg_d;
	logic                    digits_q, digits_d;
	logic                    frac_q, frac_d;
	logic                    tok_q, tok_d;
	logic                    ovf_q, ovf_d;
	logic signed [IDX_W-1:0] part_q [3];
	logic signed [IDX_W-1:0] part_d [3];
	vert_t                   held_q, held_d;
	logic                    hv_q, hv_d;
	logic                    adv;

	function automatic fin_t fin_val(input logic [INDEX_BITS-1:0] acc, input logic neg,
			input logic digits, input logic [VC_W-1:0] vc);
		logic signed [CALC_W-1:0] k;
		logic signed [CALC_W-1:0] r;
		fin_t                     f;
		k = signed'(CALC_W'(acc));
		if (neg) begin
			k = -k;
		end
		r = k - ONE_C;
		if (r[CALC_W-1]) begin
			r = r + signed'(CALC_W'(vc)) + ONE_C;
		end
		f.ovf = 1'b0;
		if (r < MINUS1_C) begin
			r = MINUS1_C;
		end
		if (r > OUTMAX_C) begin
			r = OUTMAX_C;
			f.ovf = 1'b1;
		end
		f.r = r[IDX_W-1:0];
		if (!digits) begin
			f.r = NONE_C;
			f.ovf = 1'b0;
		end
		return f;
	endfunction

	assign chars.ready = !valid_s1 || room;
	assign adv = valid_s1 && room;

	always_comb begin
		logic              sp;
		logic              e0;
		logic              e1;
		vert_t             v0;
		vert_t             v1;
		fin_t              fin;
		logic [PROD_W-1:0] prod;
		acc_d = acc_q;
		fpos_d = fpos_q;
		neg_d = neg_q;
		digits_d = digits_q;
		frac_d = frac_q;
		tok_d = tok_q;
		ovf_d = ovf_q;
		part_d = part_q;
		held_d = held_q;
		hv_d = hv_q;
		e0 = 1'b0;
		e1 = 1'b0;
		v0 = held_q;
		v0.last = 1'b0;
		sp = (ch_s1 == CH_SPACE) || (ch_s1 inside {[CH_TAB:CH_CR]});
		prod = PROD_W'({acc_q, 3'b000}) + PROD_W'({acc_q, 1'b0}) + PROD_W'(ch_s1 - CH_ZERO);
		fin = fin_val(acc_q, neg_q, digits_q, vc_s1);

		if (!sp) begin
			if (!tok_q) begin
				if (hv_q) begin
					e0 = 1'b1;
					hv_d = 1'b0;
				end
				tok_d = 1'b1;
			end
			if (fpos_q <= LAST_FIELD) begin
				if (ch_s1 inside {[CH_ZERO:CH_NINE]}) begin
					if (!frac_q) begin
						if (prod > ACCMAX_C) begin
							acc_d = '1;
							ovf_d = 1'b1;
						end else begin
							acc_d = prod[INDEX_BITS-1:0];
						end
					end
					digits_d = 1'b1;
				end else if (ch_s1 == CH_MINUS) begin
					if (!digits_q && !frac_q) begin
						neg_d = 1'b1;
					end
				end else if (ch_s1 == CH_DOT) begin
					frac_d = 1'b1;
				end else if (ch_s1 == CH_SLASH) begin
					part_d[fpos_q] = fin.r;
					ovf_d = ovf_d | fin.ovf;
					acc_d = '0;
					neg_d = 1'b0;
					digits_d = 1'b0;
					frac_d = 1'b0;
					fpos_d = fpos_q + 2'd1;
				end
			end
		end

		if (tok_d && (sp || eol_s1)) begin
			fin = fin_val(acc_d, neg_d, digits_d, vc_s1);
			if (fpos_d <= LAST_FIELD) begin
				part_d[fpos_d] = fin.r;
				ovf_d = ovf_d | fin.ovf;
			end
			held_d.v_index = part_d[0];
			held_d.t_index = part_d[1];
			held_d.n_index = part_d[2];
			held_d.overflow = ovf_d;
			held_d.last = 1'b0;
			hv_d = 1'b1;
			acc_d = '0;
			neg_d = 1'b0;
			digits_d = 1'b0;
			frac_d = 1'b0;
			fpos_d = '0;
			tok_d = 1'b0;
			ovf_d = 1'b0;
			part_d[0] = NONE_C;
			part_d[1] = NONE_C;
			part_d[2] = NONE_C;
		end

		v1 = held_d;
		v1.last = 1'b1;
		if (eol_s1) begin
			if (hv_d) begin
				e1 = 1'b1;
				hv_d = 1'b0;
			end
			acc_d = '0;
			neg_d = 1'b0;
			digits_d = 1'b0;
			frac_d = 1'b0;
			fpos_d = '0;
			tok_d = 1'b0;
			ovf_d = 1'b0;
			part_d[0] = NONE_C;
			part_d[1] = NONE_C;
			part_d[2] = NONE_C;
		end

		push.num = 2'({1'b0, e0 & adv} + {1'b0, e1 & adv});
		push.first = e0 ? v0 : v1;
		push.second = v1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1 <= chars.ch;
			eol_s1 <= chars.end_of_line;
			vc_s1 <= chars.vertex_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			fpos_q <= '0;
			neg_q <= 1'b0;
			digits_q <= 1'b0;
			frac_q <= 1'b0;
			tok_q <= 1'b0;
			ovf_q <= 1'b0;
			part_q[0] <= NONE_C;
			part_q[1] <= NONE_C;
			part_q[2] <= NONE_C;
			hv_q <= 1'b0;
		end else if (adv) begin
			acc_q <= acc_d;
			fpos_q <= fpos_d;
			neg_q <= neg_d;
			digits_q <= digits_d;
			frac_q <= frac_d;
			tok_q <= tok_d;
			ovf_q <= ovf_d;
			part_q <= part_d;
			hv_q <= hv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			held_q <= held_d;
		end
	end

endmodule

// ----- hdl/ofip_out_fifo.sv -----
// Four-entry result queue that takes up to two vertices per cycle.
module ofip_out_fifo import ofip_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	output logic          room,
	ofip_vert_if.source   verts
);

	vert_t      mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign room = cnt_q <= 3'd2;
	assign pop = verts.valid && verts.ready;
	assign verts.valid = cnt_q != 3'd0;
	assign verts.v_index = mem_q[rd_q].v_index;
	assign verts.t_index = mem_q[rd_q].t_index;
	assign verts.n_index = mem_q[rd_q].n_index;
	assign verts.last = mem_q[rd_q].last;
	assign verts.overflow = mem_q[rd_q].overflow;

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_q + 2'd1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + push.num;
			rd_q <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.num} - {2'b00, pop};
		end
	end

endmodule
